@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL files that check themselves.
// They expect signals named clk and rst_n in the including scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |=> (cons))) \
    else $error(msg);

`endif

@@ hdl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Widths, codes, state encoding and saturation helpers of the clamped PID
// controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Data format: signed Q16.16, time step unsigned Q0.16
  localparam int DW      = 32;
  localparam int FB      = 16;
  localparam int DT_W    = 16;
  localparam int PROD_W  = 2 * DW;
  localparam int DIVD_W  = DW + DT_W;
  localparam int CNT_W   = $clog2(DIVD_W);
  localparam int LIM_W   = DW - 1;
  localparam int ACC_W   = DW + 2;

  localparam logic [DT_W-1:0] DT_DEFAULT = DT_W'(66);

  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PROD_W-1:0] MAG_POS_LIM = {{(PROD_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [PROD_W-1:0] MAG_NEG_LIM = {{(PROD_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  // Item action codes
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_TARGET      = 3'd3,
    REG_FEEDFORWARD = 3'd4,
    REG_DRIVE_MIN   = 3'd5,
    REG_DRIVE_MAX   = 3'd6,
    REG_INTEG_LIMIT = 3'd7
  } cfg_idx_t;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_ERR      = 12'b0000_0000_0010,
    ST_MUL_P    = 12'b0000_0000_0100,
    ST_MUL_E    = 12'b0000_0000_1000,
    ST_SUM      = 12'b0000_0001_0000,
    ST_MUL_I    = 12'b0000_0010_0000,
    ST_MUL_D    = 12'b0000_0100_0000,
    ST_DVAL     = 12'b0000_1000_0000,
    ST_DIV_GO   = 12'b0001_0000_0000,
    ST_DIV_WAIT = 12'b0010_0000_0000,
    ST_TOTAL    = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_t;

  // Magnitude of a signed value; the most negative value fits unsigned
  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Signed value from a magnitude and a sign, saturated to DW bits
  function automatic logic signed [DW-1:0] sat_mag(input logic [PROD_W-1:0] m,
                                                   input logic neg);
    logic signed [DW-1:0] r;
    if (!neg) begin
      r = (m > MAG_POS_LIM) ? VAL_MAX : $signed(m[DW-1:0]);
    end else begin
      r = (m > MAG_NEG_LIM) ? VAL_MIN : $signed(DW'(-m[DW-1:0]));
    end
    return r;
  endfunction

  // One extra bit of headroom folded back into DW bits
  function automatic logic signed [DW-1:0] sat_wide(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? VAL_MIN : VAL_MAX;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/pidc_ifs.sv @@
// ----------------------------------------------------------------------------
// pidc_ifs
// Valid/ready channels of the PID controller: update items in, drive out.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  import pidc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic signed [DW-1:0] sample;
  logic [DT_W-1:0]      interval;

  modport source (output valid, action, sample, interval, input ready);
  modport sink   (input valid, action, sample, interval, output ready);
endinterface

interface pidc_out_if;
  import pidc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive;
  logic                 drive_clipped;
  logic                 sum_clipped;

  modport source (output valid, drive, drive_clipped, sum_clipped, input ready);
  modport sink   (input valid, drive, drive_clipped, sum_clipped, output ready);
endinterface

@@ hdl/pidc_mul.sv @@
// ----------------------------------------------------------------------------
// pidc_mul
// Shared unsigned magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidc_mul (
  input  logic                           clk,
  input  logic [pidc_pkg::DW-1:0]        mul_a,
  input  logic [pidc_pkg::DW-1:0]        mul_b,
  output logic [pidc_pkg::PROD_W-1:0]    prod_r
);
  import pidc_pkg::*;

  // Product is registered and ready in the cycle after the operands are presented
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

@@ hdl/pidc_div.sv @@
// ----------------------------------------------------------------------------
// pidc_div
// Restoring divider, one quotient bit per cycle, for the derivative term.
// ----------------------------------------------------------------------------
module pidc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          div_start,
  input  logic [pidc_pkg::DIVD_W-1:0]   dividend,
  input  logic [pidc_pkg::DT_W-1:0]     divisor,
  output logic                          div_done,
  output logic [pidc_pkg::DIVD_W-1:0]   quot
);
  import pidc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DT_W-1:0]   rem_r;
  logic [DT_W-1:0]   dsr_r;
  logic [DT_W:0]     trial;
  logic              q_bit;
  logic [DT_W-1:0]   rem_nxt;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    q_bit   = (trial >= {1'b0, dsr_r});
    rem_nxt = q_bit ? DT_W'(trial - {1'b0, dsr_r}) : trial[DT_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top as quotient bits shift in
  always_ff @(posedge clk) begin
    if (div_start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign div_done = done_r;
  assign quot     = quo_r;

endmodule

@@ hdl/pid_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Positional PID controller, signed Q16.16, with integral and drive clamps.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: action (update or clear), the
//   measured sample and the time step interval (Q0.16 s, zero means 66).
//   out_ch returns exactly one result per item: the drive and two clip flags.
//   cfg_we/cfg_index/cfg_data write the gains, target, feedforward, drive
//   window and integral limit; write them only while the block is idle.
//   Changing a gain clears the integral and the last error.
// Sequence:
//   An update runs eight sequencer steps around the one shared 32x32
//   multiplier, then the bit-serial divider for the derivative term, then
//   the final sum. A clear item goes straight from idle to the result step.
//   in_ch.ready is high only while idle, so a new item is taken only after
//   the last one has reached the output register.
// Reset and stall:
//   Synchronous reset loads the register defaults and zeroes the state.
//   The result sits in an output register; the next item is accepted while
//   it waits, and that item holds in its last step until out_ch is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_controller_clamped (
  input  logic                    clk,
  input  logic                    rst_n,
  pidc_in_if.sink                 in_ch,
  pidc_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  pidc_pkg::cfg_idx_t      cfg_index,
  input  logic [pidc_pkg::DW-1:0] cfg_data
);
  import pidc_pkg::*;

  // Configuration registers
  logic signed [DW-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic signed [DW-1:0] target_r, feedforward_r, drive_min_r, drive_max_r;
  logic [LIM_W-1:0]     integ_limit_r;

  // Controller state and item work registers
  state_t               state_r, state_nxt;
  logic signed [DW-1:0] error_sum_r, last_err_r;
  logic signed [DW-1:0] sample_r, err_r, diff_r, pt_r, it_r;
  logic [DT_W-1:0]      dt_r;
  logic [DW-1:0]        dv_mag_r;
  logic                 dv_neg_r;
  logic                 clear_r, sclip_r;
  logic signed [ACC_W-1:0] part_r, total_r;

  // Output register
  logic                 out_valid_r;
  logic signed [DW-1:0] out_drive_r;
  logic                 out_dclip_r, out_sclip_r;

  // Shared units
  logic [DW-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]    prod_r;
  logic                 div_start, div_done;
  logic [DIVD_W-1:0]    quot;

  logic                 in_xfer, out_free, gain_clear;
  logic signed [DW-1:0] prod_val, quot_val;
  logic signed [ACC_W-1:0] inc_v, sum_v, lim_v, max_v, min_v, clamp1_v, clamp2_v;
  logic                 dclip_v;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  pidc_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  pidc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .dividend  ({dv_mag_r, {DT_W{1'b0}}}),
    .divisor   (dt_r),
    .div_done  (div_done),
    .quot      (quot)
  );

  // Multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_P: begin
        mul_a = mag_of(prop_gain_r);
        mul_b = mag_of(err_r);
      end
      ST_MUL_E: begin
        mul_a = mag_of(err_r);
        mul_b = DW'(dt_r);
      end
      ST_MUL_I: begin
        mul_a = mag_of(integ_gain_r);
        mul_b = mag_of(error_sum_r);
      end
      ST_MUL_D: begin
        mul_a = mag_of(deriv_gain_r);
        mul_b = mag_of(diff_r);
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_DIV_GO);

  // Product with its sign, shifted to Q16.16 and saturated
  always_comb begin
    prod_val = '0;
    unique case (state_r)
      ST_MUL_E: prod_val = sat_mag({{FB{1'b0}}, prod_r[PROD_W-1:FB]},
                                   prop_gain_r[DW-1] ^ err_r[DW-1]);
      ST_MUL_D: prod_val = sat_mag({{FB{1'b0}}, prod_r[PROD_W-1:FB]},
                                   integ_gain_r[DW-1] ^ error_sum_r[DW-1]);
      ST_DVAL:  prod_val = sat_mag({{FB{1'b0}}, prod_r[PROD_W-1:FB]},
                                   deriv_gain_r[DW-1] ^ diff_r[DW-1]);
      default:  prod_val = '0;
    endcase
  end

  // Integral step: increment, add, clamp to the limit
  always_comb begin
    inc_v = $signed({2'b00, prod_r[FB +: DW]});
    if (err_r[DW-1]) begin
      inc_v = -inc_v;
    end
    sum_v = ACC_W'(error_sum_r) + inc_v;
    lim_v = $signed({{(ACC_W-LIM_W){1'b0}}, integ_limit_r});
  end

  // Derivative quotient and the drive window
  always_comb begin
    quot_val = sat_mag(PROD_W'(quot), dv_neg_r);
    max_v    = ACC_W'(drive_max_r);
    min_v    = ACC_W'(drive_min_r);
    dclip_v  = 1'b0;
    clamp1_v = total_r;
    if (total_r > max_v) begin
      clamp1_v = max_v;
      dclip_v  = 1'b1;
    end
    clamp2_v = clamp1_v;
    if (clamp1_v < min_v) begin
      clamp2_v = min_v;
      dclip_v  = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_xfer) begin
                     state_nxt = (in_ch.action == ACT_CLEAR) ? ST_DONE : ST_ERR;
                   end
      ST_ERR:      state_nxt = ST_MUL_P;
      ST_MUL_P:    state_nxt = ST_MUL_E;
      ST_MUL_E:    state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_MUL_I;
      ST_MUL_I:    state_nxt = ST_MUL_D;
      ST_MUL_D:    state_nxt = ST_DVAL;
      ST_DVAL:     state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) begin
                     state_nxt = ST_TOTAL;
                   end
      ST_TOTAL:    state_nxt = ST_DONE;
      ST_DONE:     if (out_free) begin
                     state_nxt = ST_IDLE;
                   end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes; a changed gain clears the integral state
  always_comb begin
    gain_clear = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  gain_clear = (cfg_data != prop_gain_r);
        REG_INTEG_GAIN: gain_clear = (cfg_data != integ_gain_r);
        REG_DERIV_GAIN: gain_clear = (cfg_data != deriv_gain_r);
        default:        gain_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      target_r      <= '0;
      feedforward_r <= '0;
      drive_min_r   <= '0;
      drive_max_r   <= DW'(327680);
      integ_limit_r <= LIM_W'(1310720);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
        REG_TARGET:      target_r      <= cfg_data;
        REG_FEEDFORWARD: feedforward_r <= cfg_data;
        REG_DRIVE_MIN:   drive_min_r   <= cfg_data;
        REG_DRIVE_MAX:   drive_max_r   <= cfg_data;
        REG_INTEG_LIMIT: integ_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Integral and last error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      last_err_r  <= '0;
    end else if (gain_clear || (in_xfer && in_ch.action == ACT_CLEAR)) begin
      error_sum_r <= '0;
      last_err_r  <= '0;
    end else begin
      if (state_r == ST_MUL_P) begin
        last_err_r <= err_r;
      end
      if (state_r == ST_SUM) begin
        if (sum_v > lim_v) begin
          error_sum_r <= lim_v[DW-1:0];
        end else if (sum_v < -lim_v) begin
          error_sum_r <= DW'(-lim_v);
        end else begin
          error_sum_r <= sum_v[DW-1:0];
        end
      end
    end
  end

  // Item work registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_xfer) begin
        sample_r <= in_ch.sample;
        dt_r     <= (in_ch.interval == '0) ? DT_DEFAULT : in_ch.interval;
        clear_r  <= (in_ch.action == ACT_CLEAR);
        sclip_r  <= 1'b0;
      end
      ST_ERR:    err_r <= sat_wide((DW+1)'(target_r) - (DW+1)'(sample_r));
      ST_MUL_P:  diff_r <= sat_wide((DW+1)'(err_r) - (DW+1)'(last_err_r));
      ST_MUL_E:  pt_r <= prod_val;
      ST_SUM:    sclip_r <= (sum_v > lim_v) || (sum_v < -lim_v);
      ST_MUL_D:  it_r <= prod_val;
      ST_DVAL: begin
        dv_mag_r <= mag_of(prod_val);
        dv_neg_r <= prod_val[DW-1];
        part_r   <= ACC_W'(pt_r) + ACC_W'(it_r) + ACC_W'(feedforward_r);
      end
      ST_DIV_WAIT: if (div_done) begin
        total_r <= part_r + ACC_W'(quot_val);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      if (clear_r) begin
        out_drive_r <= '0;
        out_dclip_r <= 1'b0;
        out_sclip_r <= 1'b0;
      end else begin
        out_drive_r <= clamp2_v[DW-1:0];
        out_dclip_r <= dclip_v;
        out_sclip_r <= sclip_r;
      end
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive         = out_drive_r;
  assign out_ch.drive_clipped = out_dclip_r;
  assign out_ch.sum_clipped   = out_sclip_r;

  // Checks
  `ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_r != ST_IDLE, "item accepted but sequencer idle")
  `ASSERT_CLK(a_div_done_in_wait, div_done |-> state_r == ST_DIV_WAIT, "divider done outside wait")
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result without done")

endmodule
